// ===== rtl/b64se_pkg.sv =====
// Shared types, constants and the base64 alphabet lookup for the stream encoder.
package b64se_pkg;

    localparam int unsigned CapWidth       = 16;
    localparam int unsigned CharWidth      = 7;
    localparam int unsigned MaxChars       = 4;
    localparam int unsigned DefQueueDepth  = 2;

    localparam logic [CapWidth-1:0]  CapResetValue = 16'd4096;
    localparam logic [CharWidth-1:0] PadChar       = 7'h3D;

    // One queued job: the characters caused by one accepted byte.
    typedef struct packed {
        logic [MaxChars-1:0][CharWidth-1:0] chars;
        logic [1:0]                         last_idx;
        logic                               last;
    } job_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // Maps a six-bit value onto the standard base64 alphabet.
    function automatic logic [CharWidth-1:0] sextet_char(input logic [5:0] v);
        logic [CharWidth-1:0] v7;
        v7 = {1'b0, v};
        if (v < 6'd26)
            return v7 + 7'd65;
        else if (v < 6'd52)
            return v7 + 7'd71;
        else if (v < 6'd62)
            return v7 - 7'd4;
        else if (v == 6'd62)
            return 7'h2B;
        else
            return 7'h2F;
    endfunction

endpackage

// ===== rtl/b64se_if.sv =====
// Valid/ready channel interfaces for the byte input and the character output.
interface b64se_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64se_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_end;
    logic       text_end;

    modport source (output valid, output out_char, output run_end, output text_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_end, input text_end,
                    output ready);
endinterface

// ===== rtl/b64se_front.sv =====
// Front part: accepts bytes, tracks group state and capacity, and builds character jobs.
module b64se_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [15:0]                 cfg_wdata,
    b64se_byte_if.sink                  in_bytes,
    input  b64se_pkg::q_status_t        q_stat,
    output logic                        push,
    output b64se_pkg::job_t             push_job
);
    import b64se_pkg::*;

    logic [CapWidth-1:0] cap_reg;
    logic [1:0]          phase_reg, phase_next;
    logic [3:0]          held_reg, held_next;
    logic [CapWidth-1:0] count_reg, count_next;
    logic                stopped_reg, stopped_next;

    logic                accept;
    logic [1:0]          phase_eff;
    logic                fits;
    logic                stop_now;
    logic [2:0]          n_chars;
    logic [7:0]          b;
    logic                last;
    job_t                job;

    assign in_bytes.ready = !q_stat.full;
    assign accept = in_bytes.valid && in_bytes.ready;
    assign b      = in_bytes.data_byte;
    assign last   = in_bytes.last_byte;

    always_comb
    begin
        phase_eff = (phase_reg == 2'd1 || phase_reg == 2'd2) ? phase_reg : 2'd0;
        fits      = ({1'b0, count_reg} + 17'd4) < {1'b0, cap_reg};
        stop_now  = stopped_reg || (phase_eff == 2'd0 && !fits);

        job.chars    = '0;
        job.last_idx = 2'd0;
        job.last     = last;
        n_chars      = 3'd0;
        held_next    = held_reg;
        phase_next   = phase_eff;

        if (!stop_now)
        begin
            case (phase_eff)
                2'd1:
                begin
                    job.chars[0] = sextet_char({held_reg[1:0], b[7:4]});
                    held_next    = b[3:0];
                    phase_next   = 2'd2;
                    if (last)
                    begin
                        job.chars[1] = sextet_char({b[3:0], 2'b00});
                        job.chars[2] = PadChar;
                        n_chars      = 3'd3;
                    end
                    else
                    begin
                        n_chars = 3'd1;
                    end
                end
                2'd2:
                begin
                    job.chars[0] = sextet_char({held_reg, b[7:6]});
                    job.chars[1] = sextet_char(b[5:0]);
                    held_next    = 4'd0;
                    phase_next   = 2'd0;
                    n_chars      = 3'd2;
                end
                default:
                begin
                    job.chars[0] = sextet_char(b[7:2]);
                    held_next    = {2'b00, b[1:0]};
                    phase_next   = 2'd1;
                    if (last)
                    begin
                        job.chars[1] = sextet_char({b[1:0], 4'b0000});
                        job.chars[2] = PadChar;
                        job.chars[3] = PadChar;
                        n_chars      = 3'd4;
                    end
                    else
                    begin
                        n_chars = 3'd1;
                    end
                end
            endcase
        end

        job.last_idx = 2'(n_chars - 3'd1);

        if (last)
        begin
            phase_next   = 2'd0;
            held_next    = 4'd0;
            count_next   = '0;
            stopped_next = 1'b0;
        end
        else
        begin
            count_next   = count_reg + CapWidth'(n_chars);
            stopped_next = stop_now;
        end
    end

    assign push     = accept && (n_chars != 3'd0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CapResetValue;
            phase_reg   <= 2'd0;
            held_reg    <= 4'd0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg   <= phase_next;
                held_reg    <= held_next;
                count_reg   <= count_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

// ===== rtl/b64se_queue.sv =====
// Short job queue that decouples the front part from the character output.
module b64se_queue #(
    parameter int unsigned DEPTH = b64se_pkg::DefQueueDepth
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64se_pkg::job_t       push_job,
    input  logic                  pop,
    output b64se_pkg::job_t       head,
    output b64se_pkg::q_status_t  stat
);
    import b64se_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    job_t            slots [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign stat.not_empty = (cnt_reg != '0);
    assign stat.full      = (cnt_reg == CntW'(DEPTH));
    assign head           = slots[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && stat.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/b64se_back.sv =====
// Back part: walks the head job one character per cycle, unless stalled, into the output register.
module b64se_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64se_pkg::job_t       head,
    input  b64se_pkg::q_status_t  q_stat,
    output logic                  pop,
    b64se_char_if.source          out_chars
);
    import b64se_pkg::*;

    logic                 ov_reg, ov_next;
    logic [CharWidth-1:0] char_reg;
    logic                 run_end_reg;
    logic                 text_end_reg;
    logic [1:0]           idx_reg, idx_next;
    logic                 advance;
    logic                 load;
    logic                 at_end;

    assign advance = !ov_reg || out_chars.ready;
    assign load    = advance && q_stat.not_empty;
    assign at_end  = (idx_reg == head.last_idx);
    assign pop     = load && at_end;

    always_comb
    begin
        ov_next  = advance ? q_stat.not_empty : ov_reg;
        idx_next = idx_reg;
        if (pop)
            idx_next = 2'd0;
        else if (load)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg     <= head.chars[idx_reg];
            run_end_reg  <= at_end;
            text_end_reg <= at_end && head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            ov_reg  <= ov_next;
            idx_reg <= idx_next;
        end
    end

    assign out_chars.valid    = ov_reg;
    assign out_chars.out_char = char_reg;
    assign out_chars.run_end  = run_end_reg;
    assign out_chars.text_end = text_end_reg;

endmodule

// ===== rtl/base64_stream_encoder_top.sv =====
// Top level of the streaming base64 encoder.
//
// The block takes message bytes on in_bytes, one per transaction, with last_byte
// marking the final byte, and delivers base64 characters on out_chars, one per
// transaction. Every three bytes give four characters; a final partial group is
// completed with one or two '=' pad characters. run_end flags the last character
// caused by an input byte and text_end the last one caused by the final byte. Before
// each group starts, the characters already sent plus four must be below
// out_capacity (written through cfg_we/cfg_wdata while idle, reset value 4096);
// otherwise the rest of the message produces no characters, and the last byte
// still clears the message state. A byte is taken in the cycle it is offered as
// long as the job queue (QUEUE_DEPTH entries, two by default) has room. The
// output side sends one character per cycle while the receiver is ready, so the
// character port sets the rate, and a final byte that closes a one-byte group
// occupies the output for four characters. The first character of a byte passes
// through the job queue and the output register before it appears at the output.
module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = b64se_pkg::DefQueueDepth
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    b64se_byte_if.sink    in_bytes,
    b64se_char_if.source  out_chars
);
    import b64se_pkg::*;

    // Jobs from the front part and the queue's status and head entry.
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      head;
    q_status_t q_stat;

    // The front part classifies each byte by its place in the three-byte group
    // and checks capacity, then hands the resulting characters over as one job.
    b64se_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_bytes (in_bytes),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // The queue lets the front keep taking bytes while characters drain.
    b64se_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    // The back part sends one character per cycle through a registered output while the receiver is ready.
    b64se_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .out_chars(out_chars)
    );

endmodule

// ===== rtl/b64se_checker.sv =====
// Port-level checks for the base64 stream encoder and the bind that attaches them.
module b64se_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_char,
    input logic       run_end,
    input logic       text_end
);

    // A message end is always the last character of its byte.
    a_text_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_end)
        else $error("text_end without run_end");

    // A pad character that ends a byte's characters also ends the message.
    a_pad_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == 7'h3D && run_end |-> text_end)
        else $error("pad character ends a byte but not the message");

    // Every character is in the base64 alphabet or is padding.
    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char >= 7'h41 && out_char <= 7'h5A) ||
                      (out_char >= 7'h61 && out_char <= 7'h7A) ||
                      (out_char >= 7'h30 && out_char <= 7'h39) ||
                      out_char == 7'h2B || out_char == 7'h2F || out_char == 7'h3D)
        else $error("illegal output character");

    // A stalled character holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) &&
                                    $stable(run_end) && $stable(text_end))
        else $error("stalled output changed");

endmodule

bind base64_stream_encoder_top b64se_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_chars.valid),
    .out_ready(out_chars.ready),
    .out_char (out_chars.out_char),
    .run_end  (out_chars.run_end),
    .text_end (out_chars.text_end)
);

// ===== test/base64_stream_encoder_top_tb.sv =====
// Self-checking testbench for the streaming base64 encoder top level.
module base64_stream_encoder_top_tb;

    import b64se_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 6;
    // Cycles to wait for outstanding characters before settle() gives up.
    localparam int SETTLE_LIMIT = 2000;
    // Cycles waited after the last owed character before settle() returns, to cover the
    // job queue (two entries plus the output stage, with margin).
    localparam int DRAIN_CYCLES = 12;
    // Receiver hold-off used to fill the job queue and stall the input side.
    localparam int LONG_HOLD    = 60;
    // Mismatch lines printed before the report goes quiet (the count goes on).
    localparam int PRINT_LIMIT  = 40;

    // One character as the encoder should deliver it.
    typedef struct {
        logic [CharWidth-1:0] ch;
        logic                 run_end;
        logic                 text_end;
    } enc_char_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                cfg_we;
    logic [CapWidth-1:0] cfg_wdata;

    b64se_byte_if in_bus ();
    b64se_char_if out_bus ();

    base64_stream_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_bytes  (in_bus),
        .out_chars (out_bus)
    );

    // The clock runs from time zero; the first rising edge comes at 2.
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Encoder state as the testbench tracks it. These mirror the block's own
    // message state and the capacity register, and are only touched at the
    // clock edge where a byte or a register write is taken.
    string               alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [CapWidth-1:0] cap_limit   = CapResetValue;
    logic [1:0]          enc_phase   = 2'd0;
    logic [3:0]          enc_held    = 4'd0;
    logic [15:0]         enc_count   = 16'd0;
    logic                enc_stopped = 1'b0;

    // Characters the block owes us, oldest first.
    enc_char_t pending_chars [$];

    int mismatches = 0;

    // Knobs for the two sides. Both idle in short random bursts by default;
    // the last part of the run turns both off. A test can also ask the
    // receiver for one long hold-off.
    bit src_bursts        = 1'b1;
    bit sink_bursts       = 1'b1;
    int sink_hold_request = 0;
    int sink_stall        = 0;

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [CharWidth-1:0] b64_symbol(input logic [5:0] v);
        byte c;
        c = alphabet[v];
        return c[CharWidth-1:0];
    endfunction

    // Works out the characters that one accepted byte causes and queues them.
    // A group only starts when the characters already sent plus four stay below
    // the capacity; once that fails the rest of the message is dropped.
    function automatic void encode_byte(input logic [7:0] data, input logic is_last);
        logic [CharWidth-1:0] chars [4];
        enc_char_t            e;
        int                   n;
        n = 0;
        if (enc_phase != 2'd1 && enc_phase != 2'd2)
        begin
            enc_phase = 2'd0;
            if (!enc_stopped && !(int'(enc_count) + 4 < int'(cap_limit)))
                enc_stopped = 1'b1;
        end
        if (!enc_stopped)
        begin
            case (enc_phase)
                2'd1:
                begin
                    chars[0] = b64_symbol({enc_held[1:0], data[7:4]});
                    enc_held = data[3:0];
                    n = 1;
                    if (is_last)
                    begin
                        chars[1] = b64_symbol({data[3:0], 2'b00});
                        chars[2] = PadChar;
                        n = 3;
                    end
                    enc_phase = 2'd2;
                end
                2'd2:
                begin
                    chars[0] = b64_symbol({enc_held, data[7:6]});
                    chars[1] = b64_symbol(data[5:0]);
                    enc_held = 4'd0;
                    n = 2;
                    enc_phase = 2'd0;
                end
                default:
                begin
                    chars[0] = b64_symbol(data[7:2]);
                    enc_held = {2'b00, data[1:0]};
                    n = 1;
                    if (is_last)
                    begin
                        chars[1] = b64_symbol({data[1:0], 4'b0000});
                        chars[2] = PadChar;
                        chars[3] = PadChar;
                        n = 4;
                    end
                    enc_phase = 2'd1;
                end
            endcase
        end
        enc_count = enc_count + 16'(n);
        for (int i = 0; i < n; i++)
        begin
            e.ch       = chars[i];
            e.run_end  = (i == n - 1);
            e.text_end = (i == n - 1) && is_last;
            pending_chars.push_back(e);
        end
        // The final byte always clears the message state, even after truncation.
        if (is_last)
        begin
            enc_phase   = 2'd0;
            enc_held    = 4'd0;
            enc_count   = 16'd0;
            enc_stopped = 1'b0;
        end
    endfunction

    // Receiver. Each cycle it decides whether ready is low; a stall is counted
    // down here, whether it is a short random burst or the long hold-off.
    initial
    begin
        out_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (sink_stall == 0)
            begin
                if (sink_hold_request != 0)
                begin
                    sink_stall = sink_hold_request;
                    sink_hold_request = 0;
                end
                else if (sink_bursts && $urandom_range(0, 4) == 0)
                    sink_stall = $urandom_range(1, 4);
            end
            if (sink_stall != 0)
            begin
                out_bus.ready <= 1'b0;
                sink_stall--;
            end
            else
                out_bus.ready <= 1'b1;
        end
    end

    // Every character transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_chars
        enc_char_t want;
        if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        begin
            if (pending_chars.size() == 0)
                flag_mismatch($sformatf("unexpected character 0x%02h", out_bus.out_char));
            else
            begin
                want = pending_chars.pop_front();
                if (out_bus.out_char !== want.ch)
                    flag_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                            out_bus.out_char, want.ch));
                if (out_bus.run_end !== want.run_end)
                    flag_mismatch($sformatf("run_end %b, expected %b",
                                            out_bus.run_end, want.run_end));
                if (out_bus.text_end !== want.text_end)
                    flag_mismatch($sformatf("text_end %b, expected %b",
                                            out_bus.text_end, want.text_end));
            end
        end
    end

    // Offers one byte and returns at the edge where it is taken. Valid is left
    // high so that a following byte can go out back to back; settle() drops it
    // when the sender stops.
    task automatic send_byte(input logic [7:0] data, input logic is_last);
        if (src_bursts && $urandom_range(0, 3) == 0)
        begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= data;
        in_bus.last_byte <= is_last;
        do
            @(posedge clk);
        while (in_bus.ready !== 1'b1);
        encode_byte(data, is_last);
    endtask

    // One message of random bytes, with all-zero and all-one bytes mixed in.
    task automatic send_message(input int msg_len);
        logic [7:0] data;
        for (int i = 0; i < msg_len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                data = 8'($urandom());
            send_byte(data, i == msg_len - 1);
        end
    endtask

    // Stops offering bytes and waits for every owed character, then waits out
    // DRAIN_CYCLES as well.
    task automatic settle();
        int waited;
        waited = 0;
        in_bus.valid <= 1'b0;
        while (pending_chars.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The capacity register is only written once the block has gone quiet.
    task automatic set_capacity(input logic [CapWidth-1:0] value);
        settle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_limit = value;
    endtask

    // Messages of one to four bytes under the reset capacity, so that every
    // group position ends a message and both pad lengths show up.
    task automatic test_short_messages();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Capacity limits: a message cut off in its third group so that its last
    // byte gives nothing, a following message that must be whole again, a
    // capacity of one where nothing gets out, and one that admits one group.
    task automatic test_truncation();
        set_capacity(16'd9);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h21, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b1);
        set_capacity(16'd1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        set_capacity(16'd5);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
        send_byte(8'h9A, 1'b1);
    endtask

    // The receiver holds off for a long stretch while bytes keep coming, so the
    // job queue fills and the input stalls. Afterwards the sender waits until
    // every character has come out.
    task automatic test_backpressure();
        set_capacity(CapResetValue);
        src_bursts = 1'b0;
        sink_hold_request = LONG_HOLD;
        send_message(12);
        settle();
        src_bursts = 1'b1;
    endtask

    // Random messages across a range of capacities: the reset value, the top
    // of the range, small ones that truncate often, zero and one where nothing
    // is sent, and an arbitrary one.
    task automatic test_random_messages();
        int budget;
        int sent;
        int msg_len;
        for (int step = 0; step < 8; step++)
        begin
            budget = 52;
            case (step)
                0: set_capacity(16'd4096);
                1: set_capacity(16'hFFFF);
                2: set_capacity(16'($urandom_range(5, 30)));
                3: set_capacity(16'($urandom_range(31, 200)));
                4:
                begin
                    set_capacity(16'd1);
                    budget = 12;
                end
                5:
                begin
                    set_capacity(16'd0);
                    budget = 12;
                end
                6: set_capacity(16'($urandom()));
                default: set_capacity(16'd4096);
            endcase
            sent = 0;
            while (sent < budget)
            begin
                if ($urandom_range(0, 7) == 0)
                    msg_len = $urandom_range(13, 40);
                else
                    msg_len = $urandom_range(1, 12);
                send_message(msg_len);
                sent += msg_len;
                // Now and then the sender waits for the block to drain.
                if ($urandom_range(0, 9) == 0)
                    settle();
            end
        end
    endtask

    // Closing stretch with no idling on either side, at full rate.
    task automatic test_steady_flow();
        set_capacity(CapResetValue);
        src_bursts  = 1'b0;
        sink_bursts = 1'b0;
        send_message(1);
        send_message(2);
        send_message(3);
        send_message(10);
        send_message(24);
    endtask

    initial
    begin
        in_bus.valid     <= 1'b0;
        in_bus.data_byte <= 8'h00;
        in_bus.last_byte <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_messages();
        test_truncation();
        test_backpressure();
        test_random_messages();
        test_steady_flow();

        settle();
        if (pending_chars.size() != 0)
            flag_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #(CLK_PERIOD * 300000);
        $display("timeout: the run did not finish");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== base64_stream_encoder_top.f =====
rtl/b64se_pkg.sv
rtl/b64se_if.sv
rtl/b64se_front.sv
rtl/b64se_queue.sv
rtl/b64se_back.sv
rtl/base64_stream_encoder_top.sv
rtl/b64se_checker.sv
test/base64_stream_encoder_top_tb.sv
